// ----- rtl/acpm_pkg.sv -----
// acpm_pkg: shared types and constants of the adapter current power monitor
// no dependencies; used by acpm_cfg_regs and adapter_current_power_monitor_core
`default_nettype none

package acpm_pkg;

  localparam int DefaultSampleBits  = 10;
  localparam int DefaultWindowDepth = 4;
  localparam int DefaultCheckPeriod = 200;

  localparam int LimitBits   = 10;
  localparam int PercentBits = 7;
  localparam int GpuBits     = 2;
  localparam int CfgIdxBits  = 3;

  localparam logic [PercentBits-1:0] LowChargePercent = 7'd10;

  localparam logic [GpuBits-1:0] GpuUma      = 2'h1;
  localparam logic [GpuBits-1:0] GpuDiscrete = 2'h2;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgProchotDiscrete = 3'd0,
    CfgProchotUma      = 3'd1,
    CfgTurboOff        = 3'd2,
    CfgTurboOn         = 3'd3,
    CfgHybridEnter     = 3'd4,
    CfgHybridExit      = 3'd5,
    CfgMinCharge       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [LimitBits-1:0]   prochot_limit_discrete;
    logic [LimitBits-1:0]   prochot_limit_uma;
    logic [LimitBits-1:0]   turbo_off_limit;
    logic [LimitBits-1:0]   turbo_on_limit;
    logic [LimitBits-1:0]   hybrid_enter_limit;
    logic [LimitBits-1:0]   hybrid_exit_limit;
    logic [PercentBits-1:0] min_charge_percent;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    prochot_limit_discrete: 10'd1023,
    prochot_limit_uma:      10'd1023,
    turbo_off_limit:        10'd1023,
    turbo_on_limit:         10'd0,
    hybrid_enter_limit:     10'd0,
    hybrid_exit_limit:      10'd0,
    min_charge_percent:     7'd10
  };

endpackage

`default_nettype wire

// ----- rtl/acpm_cfg_regs.sv -----
// acpm_cfg_regs: configuration register file of the power monitor
// depends on acpm_pkg for the register index codes and cfg_t
`default_nettype none

module acpm_cfg_regs import acpm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [LimitBits-1:0]  cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgProchotDiscrete: cfg_d.prochot_limit_discrete = cfg_data_i;
        CfgProchotUma:      cfg_d.prochot_limit_uma      = cfg_data_i;
        CfgTurboOff:        cfg_d.turbo_off_limit        = cfg_data_i;
        CfgTurboOn:         cfg_d.turbo_on_limit         = cfg_data_i;
        CfgHybridEnter:     cfg_d.hybrid_enter_limit     = cfg_data_i;
        CfgHybridExit:      cfg_d.hybrid_exit_limit      = cfg_data_i;
        CfgMinCharge:       cfg_d.min_charge_percent     = cfg_data_i[PercentBits-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/adapter_current_power_monitor_core.sv -----
// adapter_current_power_monitor_core: top level of the adapter current power monitor
// depends on acpm_pkg and acpm_cfg_regs
//
// One beat per scan tick. A new input beat is taken in every cycle in which the
// skid register is empty; its result goes to the result register, or to the skid
// register while the output side stalls, and in_stall_o stays high until the skid
// register drains. The two-entry output buffer (result plus skid register)
// sustains one beat per cycle while the output does not stall. The running-sum
// window average and its constant reciprocal multiply are settled combinationally
// between the input and the result register. Register writes are taken in any
// cycle through cfg_valid_i (cfg_ready_o stays high) and must only be issued while
// the block is idle. No clearing pass runs after reset: all state is in flip-flops.
`default_nettype none

module adapter_current_power_monitor_core import acpm_pkg::*; #(
  parameter int SAMPLE_BITS  = DefaultSampleBits,
  parameter int WINDOW_DEPTH = DefaultWindowDepth,
  parameter int CHECK_PERIOD = DefaultCheckPeriod
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0] current_sample_i,
  input  wire logic                   sample_valid_i,
  input  wire logic                   in_s0_i,
  input  wire logic                   ac_present_i,
  input  wire logic                   battery_present_i,
  input  wire logic [PercentBits-1:0] battery_percent_i,
  input  wire logic [GpuBits-1:0]     gpu_type_i,
  input  wire logic                   calibrating_i,

  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0]      average_current_o,
  output logic                        adapter_prochot_o,
  output logic                        cpu_turbo_disabled_o,
  output logic                        charger_turbo_enabled_o,
  output logic                        hybrid_alarm_o,
  output logic                        resume_charger_o,

  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [LimitBits-1:0]   cfg_data_i
);

  localparam int WinShift = $clog2(WINDOW_DEPTH);
  localparam int SumBits  = SAMPLE_BITS + WinShift;
  localparam int RecShift = SumBits + WinShift;
  localparam int RecBits  = SumBits + 1;
  localparam int ProdBits = SumBits + RecBits;
  localparam longint unsigned RecipM =
      ((64'd1 << RecShift) + longint'(WINDOW_DEPTH) - 64'd1) / longint'(WINDOW_DEPTH);
  localparam int CmpBits  = (SAMPLE_BITS > LimitBits) ? SAMPLE_BITS : LimitBits;
  localparam int TickBits = (CHECK_PERIOD > 1) ? $clog2(CHECK_PERIOD + 1) : 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   prochot;
    logic                   turbo_off;
    logic                   charge_turbo;
    logic                   alarm;
    logic                   resume;
  } result_t;

  cfg_t cfg;

  acpm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  logic [SAMPLE_BITS-1:0] held_q, held_d;
  logic [SAMPLE_BITS-1:0] window_q [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] window_d [WINDOW_DEPTH];
  logic [SumBits-1:0]     sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic [TickBits-1:0]    tick_q, tick_d;
  logic                   prochot_q, prochot_d;
  logic                   turbo_off_q, turbo_off_d;
  logic                   charge_q, charge_d;
  logic                   alarm_q, alarm_d;
  logic                   resume;

  logic                   in_accept;
  logic                   active;
  logic                   low_charge;
  logic                   above_min;
  logic                   period_done;
  logic [SAMPLE_BITS-1:0] sample_new;
  logic [SumBits-1:0]     sum_new;
  logic [ProdBits-1:0]    product;
  logic [SAMPLE_BITS-1:0] avg_new;
  logic [CmpBits-1:0]     avg_cmp;

  result_t out_q, skid_q, result;
  logic    out_valid_q, skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i & ~skid_valid_q;

  assign active      = in_s0_i & ac_present_i;
  assign sample_new  = sample_valid_i ? current_sample_i : held_q;
  assign sum_new     = sum_q + SumBits'(sample_new) - SumBits'(window_q[WINDOW_DEPTH-1]);
  assign product     = ProdBits'(sum_new) * ProdBits'(RecipM);
  assign avg_new     = SAMPLE_BITS'(product >> RecShift);
  assign avg_cmp     = CmpBits'(avg_new);
  assign low_charge  = ~battery_present_i | (battery_percent_i <= LowChargePercent);
  assign above_min   = battery_percent_i > cfg.min_charge_percent;
  assign period_done = tick_q == TickBits'(CHECK_PERIOD);

  always_comb begin
    held_d      = held_q;
    window_d    = window_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    tick_d      = tick_q;
    prochot_d   = prochot_q;
    turbo_off_d = turbo_off_q;
    charge_d    = charge_q;
    alarm_d     = alarm_q;
    resume      = 1'b0;
    if (in_accept) begin
      held_d = sample_new;
      if (active) begin
        window_d[0] = sample_new;
        for (int i = 1; i < WINDOW_DEPTH; i++) begin
          window_d[i] = window_q[i-1];
        end
        sum_d = sum_new;
        avg_d = avg_new;

        if (low_charge) begin
          if (gpu_type_i == GpuDiscrete) begin
            prochot_d = avg_cmp > CmpBits'(cfg.prochot_limit_discrete);
          end else if (gpu_type_i == GpuUma) begin
            prochot_d = avg_cmp > CmpBits'(cfg.prochot_limit_uma);
          end
        end else begin
          prochot_d = 1'b0;
          if (gpu_type_i == GpuDiscrete) begin
            priority if (avg_cmp > CmpBits'(cfg.turbo_off_limit)) begin
              turbo_off_d = 1'b1;
            end else if (avg_cmp < CmpBits'(cfg.turbo_on_limit)) begin
              turbo_off_d = 1'b0;
            end else begin
              turbo_off_d = turbo_off_q;
            end
          end
        end

        if (period_done) begin
          tick_d = '0;
          if (battery_present_i) begin
            resume = ~calibrating_i;
            if (above_min) begin
              charge_d = 1'b1;
            end else begin
              charge_d = 1'b0;
              if (cfg.hybrid_enter_limit != '0) begin
                // clear wins when both limits are crossed
                if (avg_cmp > CmpBits'(cfg.hybrid_enter_limit)) begin
                  alarm_d = 1'b1;
                end
                if (avg_cmp < CmpBits'(cfg.hybrid_exit_limit)) begin
                  alarm_d = 1'b0;
                end
              end else begin
                alarm_d = 1'b0;
              end
            end
          end
        end else begin
          tick_d = tick_q + TickBits'(1);
        end
      end
    end
  end

  assign result = '{
    average:      avg_d,
    prochot:      prochot_d,
    turbo_off:    turbo_off_d,
    charge_turbo: charge_d,
    alarm:        alarm_d,
    resume:       resume
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      window_q    <= '{default: '0};
      sum_q       <= '0;
      avg_q       <= '0;
      tick_q      <= '0;
      prochot_q   <= 1'b0;
      turbo_off_q <= 1'b0;
      charge_q    <= 1'b0;
      alarm_q     <= 1'b0;
    end else begin
      held_q      <= held_d;
      window_q    <= window_d;
      sum_q       <= sum_d;
      avg_q       <= avg_d;
      tick_q      <= tick_d;
      prochot_q   <= prochot_d;
      turbo_off_q <= turbo_off_d;
      charge_q    <= charge_d;
      alarm_q     <= alarm_d;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (!out_stall_i) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid_q && out_stall_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && out_stall_i) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign out_valid_o             = out_valid_q;
  assign average_current_o       = out_q.average;
  assign adapter_prochot_o       = out_q.prochot;
  assign cpu_turbo_disabled_o    = out_q.turbo_off;
  assign charger_turbo_enabled_o = out_q.charge_turbo;
  assign hybrid_alarm_o          = out_q.alarm;
  assign resume_charger_o        = out_q.resume;

endmodule

`default_nettype wire
